>>> sv/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet helpers for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // sextet code for a byte outside the alphabet
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    // results produced by one accepted input beat
    typedef struct packed {
        logic [3:0][7:0] bytes;     // result bytes, entry 0 leaves first
        logic [2:0]      count;     // number of result beats, 0 when none
        logic            has_data;  // clear only for a bare end marker
        logic            msg_end;   // beat carried the message end
    } b64_bundle_t;

    // sextet value to alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

    // alphabet character to sextet value, SEXTET_NONE when skipped
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = SEXTET_NONE;
        case (c) inside
            [8'h41:8'h5A]: v = 7'(c - 8'h41);
            [8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
            8'h2B:         v = 7'd62;
            8'h2F:         v = 7'd63;
            default:       v = SEXTET_NONE;
        endcase
        return v;
    endfunction

endpackage

>>> sv/b64_core.sv
// ----------------------------------------------------------------------------
// b64_core
// Group state and single-pass encode/decode logic producing one result
// bundle per accepted input beat.
// ----------------------------------------------------------------------------
module b64_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    output b64_pkg::b64_bundle_t bundle
);
    import b64_pkg::*;

    logic        direction_reg;
    logic [17:0] group_bits_reg;
    logic [1:0]  group_count_reg;
    logic [17:0] group_bits_next;
    logic [1:0]  group_count_next;

    logic [23:0] enc_bits;
    logic [1:0]  enc_count;
    logic [6:0]  sextet;
    logic [23:0] dec_bits;
    logic [2:0]  n_data;

    // encode and decode for the current beat
    always_comb begin
        bundle           = '0;
        n_data           = 3'd0;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        enc_bits         = {group_bits_reg[15:0], in_byte};
        enc_count        = group_count_reg + 2'd1;
        sextet           = sextet_of(in_byte);
        dec_bits         = {group_bits_reg[17:0], sextet[5:0]};

        if (direction_reg == DIR_ENCODE) begin
            group_bits_next  = enc_bits[17:0];
            group_count_next = enc_count;
            if (enc_count == 2'd3) begin
                bundle.bytes[0]  = char_of(enc_bits[23:18]);
                bundle.bytes[1]  = char_of(enc_bits[17:12]);
                bundle.bytes[2]  = char_of(enc_bits[11:6]);
                bundle.bytes[3]  = char_of(enc_bits[5:0]);
                n_data           = 3'd4;
                group_count_next = 2'd0;
            end else if (in_end && enc_count == 2'd1) begin
                bundle.bytes[0] = char_of(enc_bits[7:2]);
                bundle.bytes[1] = char_of({enc_bits[1:0], 4'b0000});
                bundle.bytes[2] = PAD_CHAR;
                bundle.bytes[3] = PAD_CHAR;
                n_data          = 3'd4;
            end else if (in_end && enc_count == 2'd2) begin
                bundle.bytes[0] = char_of(enc_bits[15:10]);
                bundle.bytes[1] = char_of(enc_bits[9:4]);
                bundle.bytes[2] = char_of({enc_bits[3:0], 2'b00});
                bundle.bytes[3] = PAD_CHAR;
                n_data          = 3'd4;
            end
        end else begin
            // skipped characters leave the group alone
            if (sextet != SEXTET_NONE) begin
                if (group_count_reg == 2'd3) begin
                    bundle.bytes[0]  = dec_bits[23:16];
                    bundle.bytes[1]  = dec_bits[15:8];
                    bundle.bytes[2]  = dec_bits[7:0];
                    n_data           = 3'd3;
                    group_count_next = 2'd0;
                end else begin
                    group_bits_next  = dec_bits[17:0];
                    group_count_next = group_count_reg + 2'd1;
                end
            end
            // flush a partial group, a lone sextet gives nothing
            if (in_end && n_data == 3'd0) begin
                if (group_count_next == 2'd2) begin
                    bundle.bytes[0] = group_bits_next[11:4];
                    n_data          = 3'd1;
                end else if (group_count_next == 2'd3) begin
                    bundle.bytes[0] = group_bits_next[17:10];
                    bundle.bytes[1] = group_bits_next[9:2];
                    n_data          = 3'd2;
                end
            end
        end

        bundle.msg_end  = in_end;
        bundle.has_data = (n_data != 3'd0);
        bundle.count    = n_data;
        // bare end marker
        if (in_end && n_data == 3'd0) begin
            bundle.count = 3'd1;
        end
        if (in_end) begin
            group_bits_next  = '0;
            group_count_next = 2'd0;
        end
    end

    // direction register and group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= DIR_ENCODE;
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
        end else if (cfg_we) begin
            direction_reg   <= cfg_wdata;
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
        end else if (in_accept) begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule

>>> sv/b64_emit.sv
// ----------------------------------------------------------------------------
// b64_emit
// Result register holding one bundle and sending its entries one beat per
// cycle on the master side while m_tready is high.
// ----------------------------------------------------------------------------
module b64_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  b64_pkg::b64_bundle_t bundle_in,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_byte
    output logic [1:0]           m_tuser,   // [0] has_data, [1] run_last
    output logic                 m_tlast    // message_done
);
    import b64_pkg::*;

    b64_bundle_t bundle_reg;
    logic        busy_reg;
    logic [1:0]  index_reg;
    logic        last_beat;
    logic        take;

    // beat selection
    assign last_beat = ({1'b0, index_reg} == (bundle_reg.count - 3'd1));
    assign take      = busy_reg && m_tready;
    assign free      = !busy_reg || (take && last_beat);

    assign m_tvalid   = busy_reg;
    assign m_tdata    = bundle_reg.bytes[index_reg];
    assign m_tuser[0] = bundle_reg.has_data;
    assign m_tuser[1] = last_beat;
    assign m_tlast    = last_beat && bundle_reg.msg_end;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            index_reg <= 2'd0;
        end else if (load) begin
            busy_reg  <= 1'b1;
            index_reg <= 2'd0;
        end else if (take && last_beat) begin
            busy_reg  <= 1'b0;
        end else if (take) begin
            index_reg <= index_reg + 2'd1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

>>> sv/base64_codec_top.sv
// A result's first beat is offered in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the result register is free;
// each input beat then yields 0 to 4 result beats on the single master port
// (4 per three bytes encoding, 3 per four characters decoding).
// Reset: synchronous active-low aresetn clears direction (encode), the group
// state and the result register's busy flag and index; its payload is not reset.
// ----------------------------------------------------------------------------
// base64_codec_top
// Streaming Base64 encoder/decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
module base64_codec_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,   // direction
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tlast,     // message_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic [1:0] m_tuser,     // [0] has_data, [1] run_last
    output logic       m_tlast      // message_done
);
    import b64_pkg::*;

    b64_bundle_t bundle;
    logic        in_accept;
    logic        emit_free;
    logic        load;

    // input handshake, beats with no result never load the emitter
    assign s_tready  = emit_free;
    assign in_accept = s_tvalid && s_tready;
    assign load      = in_accept && (bundle.count != 3'd0);

    b64_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .bundle    (bundle)
    );

    b64_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .bundle_in (bundle),
        .free      (emit_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // input is only taken when the result register is empty or draining
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || (m_tready && m_tuser[1])))
        else $error("input ready while result register still holds beats");

    // message end only on the last beat of an item
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("message_done without run_last");

    // a bare marker is a zero, final, message-ending beat
    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00 && m_tuser[1] && m_tlast))
        else $error("malformed bare end marker");

    // a loaded item is offered in the next cycle
    a_load_offer: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("loaded result not offered");

endmodule
